[rtl/rsi_pkg.sv]
package rsi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W   = 32;
    localparam int RSQ_W     = 31;
    localparam int MIND_W    = 16;
    localparam int DIST_W    = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 3'd4;

    localparam logic [COORD_W-1:0] CENTER_RESET   = 32'd0;
    localparam logic [RSQ_W-1:0]   RADIUS_RESET   = 31'd65536;
    localparam logic [MIND_W-1:0]  MIN_DIST_RESET = 16'd66;
    localparam logic [DIST_W-1:0]  DIST_MAX       = 31'h7FFF_FFFF;

    // Widths of the intermediate terms.
    localparam int G_W       = 33;
    localparam int A_W       = 64;
    localparam int B_W       = 66;
    localparam int C_W       = 67;
    localparam int BM_W      = 65;
    localparam int CM_W      = 66;
    localparam int PROD_W    = 130;
    localparam int RAD_W     = 132;
    localparam int ROOT_W    = 66;
    localparam int SQ_REM_W  = 67;
    localparam int SQ_STEPS  = 66;
    localparam int NUM_W     = 68;
    localparam int NUMM_W    = 67;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic              hit;
        logic              far_root;
        logic [DIST_W-1:0] distance;
    } t_hit;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [COORD_W-1:0]   value;
    } t_cfg;

endpackage

[rtl/rsi_stream_if.sv]
interface rsi_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ray_sphere_intersection_top.sv]
// Channel  Direction  Payload         Beat
// i_ray    in         rsi_pkg::t_ray  valid & ready
// o_hit    out        rsi_pkg::t_hit  valid & ready
// i_cfg    in         rsi_pkg::t_cfg  valid & ready (always ready)
//
// One beat enters per cycle while the output is not stalled; each result passes seven front
// stages, 66 root stages, two numerator stages, 31 divider stages and the output register.
// Reset clears the valid bits and loads the register defaults.
// When the output register is full and not taken, every stage holds.
module ray_sphere_intersection_top #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsi_stream_if.sink   i_ray,
    rsi_stream_if.source o_hit,
    rsi_stream_if.sink   i_cfg
);

    localparam int SQ_STEPS  = rsi_pkg::SQ_STEPS;
    localparam int DIST_W    = rsi_pkg::DIST_W;
    localparam int A_W       = rsi_pkg::A_W;
    localparam int NUMM_W    = rsi_pkg::NUMM_W;
    localparam int RAD_W     = rsi_pkg::RAD_W;
    localparam int ROOT_W    = rsi_pkg::ROOT_W;
    localparam int SQ_REM_W  = rsi_pkg::SQ_REM_W;
    localparam int CUR_W     = SQ_REM_W + 2;
    localparam int TRIAL_W   = ROOT_W + 2;
    localparam int DV_W      = ((NUMM_W + FRAC_BITS > A_W + DIST_W) ?
                                (NUMM_W + FRAC_BITS) : (A_W + DIST_W)) + 1;
    localparam int LAT       = 7 + SQ_STEPS + 2 + DIST_W + 1;

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rsq;
    logic [15:0]        r_mind;

    logic [LAT-1:0] r_vld;
    logic           w_adv;

    assign w_adv       = !r_vld[LAT-1] || o_hit.ready;
    assign i_ray.ready = w_adv;
    assign i_cfg.ready = 1'b1;
    assign o_hit.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= rsi_pkg::CENTER_RESET;
            r_cy   <= rsi_pkg::CENTER_RESET;
            r_cz   <= rsi_pkg::CENTER_RESET;
            r_rsq  <= rsi_pkg::RADIUS_RESET;
            r_mind <= rsi_pkg::MIN_DIST_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                rsi_pkg::REG_CENTER_X:  r_cx   <= i_cfg.data.value;
                rsi_pkg::REG_CENTER_Y:  r_cy   <= i_cfg.data.value;
                rsi_pkg::REG_CENTER_Z:  r_cz   <= i_cfg.data.value;
                rsi_pkg::REG_RADIUS_SQ: r_rsq  <= i_cfg.data.value[30:0];
                rsi_pkg::REG_MIN_DIST:  r_mind <= i_cfg.data.value[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_ray.valid};
        end
    end

    // Offset from the centre and direction.
    logic signed [32:0] r1_g [3];
    logic signed [31:0] r1_d [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_g[0] <= 33'(i_ray.data.origin_x) - 33'(r_cx);
            r1_g[1] <= 33'(i_ray.data.origin_y) - 33'(r_cy);
            r1_g[2] <= 33'(i_ray.data.origin_z) - 33'(r_cz);
            r1_d[0] <= i_ray.data.dir_x;
            r1_d[1] <= i_ray.data.dir_y;
            r1_d[2] <= i_ray.data.dir_z;
        end
    end

    logic signed [63:0] r2_dd [3];
    logic signed [64:0] r2_dg [3];
    logic signed [65:0] r2_gg [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r2_dd[k] <= r1_d[k] * r1_d[k];
                r2_dg[k] <= r1_d[k] * r1_g[k];
                r2_gg[k] <= r1_g[k] * r1_g[k];
            end
        end
    end

    logic [63:0]        r3_a;
    logic signed [65:0] r3_b;
    logic signed [66:0] r3_c;
    logic signed [66:0] w_rsh;

    assign w_rsh = $signed(67'(r_rsq) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_a <= r2_dd[0] + r2_dd[1] + r2_dd[2];
            r3_b <= 66'(r2_dg[0]) + 66'(r2_dg[1]) + 66'(r2_dg[2]);
            r3_c <= 67'(r2_gg[0]) + 67'(r2_gg[1]) + 67'(r2_gg[2]) - w_rsh;
        end
    end

    logic [63:0]        r4_a;
    logic signed [65:0] r4_b;
    logic [64:0]        r4_bm;
    logic [65:0]        r4_cm;
    logic               r4_cneg;
    logic               r4_az;
    logic signed [65:0] w_babs;
    logic signed [66:0] w_cabs;

    assign w_babs = r3_b[65] ? -r3_b : r3_b;
    assign w_cabs = r3_c[66] ? -r3_c : r3_c;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_a    <= r3_a;
            r4_b    <= r3_b;
            r4_bm   <= w_babs[64:0];
            r4_cm   <= w_cabs[65:0];
            r4_cneg <= r3_c[66];
            r4_az   <= (r3_a == '0);
        end
    end

    // Partial products of B*B and A*|C|.
    logic [63:0]        r5_pll, r5_qll, r5_qhl;
    logic [64:0]        r5_plh;
    logic [65:0]        r5_phh, r5_qlh, r5_qhh;
    logic [63:0]        r5_a;
    logic signed [65:0] r5_b;
    logic               r5_cneg, r5_az;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_pll  <= r4_bm[31:0] * r4_bm[31:0];
            r5_plh  <= r4_bm[31:0] * r4_bm[64:32];
            r5_phh  <= r4_bm[64:32] * r4_bm[64:32];
            r5_qll  <= r4_a[31:0] * r4_cm[31:0];
            r5_qlh  <= r4_a[31:0] * r4_cm[65:32];
            r5_qhl  <= r4_a[63:32] * r4_cm[31:0];
            r5_qhh  <= r4_a[63:32] * r4_cm[65:32];
            r5_a    <= r4_a;
            r5_b    <= r4_b;
            r5_cneg <= r4_cneg;
            r5_az   <= r4_az;
        end
    end

    logic [129:0]       r6_bb, r6_ac;
    logic [63:0]        r6_a;
    logic signed [65:0] r6_b;
    logic               r6_cneg, r6_az;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_bb   <= 130'(r5_pll) + (130'(r5_plh) << 33) + (130'(r5_phh) << 64);
            r6_ac   <= 130'(r5_qll) + (130'(r5_qlh) << 32) + (130'(r5_qhl) << 32)
                       + (130'(r5_qhh) << 64);
            r6_a    <= r5_a;
            r6_b    <= r5_b;
            r6_cneg <= r5_cneg;
            r6_az   <= r5_az;
        end
    end

    logic [RAD_W-1:0] w_disc;

    assign w_disc = r6_cneg ? (132'(r6_bb) + 132'(r6_ac)) : (132'(r6_bb) - 132'(r6_ac));

    // Square root, one result bit per stage.
    logic [SQ_REM_W-1:0] r_sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]   r_sq_root [SQ_STEPS+1];
    logic [RAD_W-1:0]    r_sq_rad  [SQ_STEPS+1];
    logic [63:0]         r_sq_a    [SQ_STEPS+1];
    logic signed [65:0]  r_sq_b    [SQ_STEPS+1];
    logic                r_sq_miss [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= w_disc;
            r_sq_a[0]    <= r6_a;
            r_sq_b[0]    <= r6_b;
            r_sq_miss[0] <= r6_az || w_disc[RAD_W-1];
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        logic [CUR_W-1:0]   w_cur;
        logic [TRIAL_W-1:0] w_trial;
        logic               w_take;

        assign w_cur   = {r_sq_rem[j], r_sq_rad[j][RAD_W-1 -: 2]};
        assign w_trial = {r_sq_root[j], 2'b01};
        assign w_take  = (w_cur >= CUR_W'(w_trial));

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_rem[j+1]  <= w_take ? SQ_REM_W'(w_cur - CUR_W'(w_trial))
                                         : SQ_REM_W'(w_cur);
                r_sq_root[j+1] <= {r_sq_root[j][ROOT_W-2:0], w_take};
                r_sq_rad[j+1]  <= r_sq_rad[j] << 2;
                r_sq_a[j+1]    <= r_sq_a[j];
                r_sq_b[j+1]    <= r_sq_b[j];
                r_sq_miss[j+1] <= r_sq_miss[j];
            end
        end
    end

    // Numerators of the two roots.
    logic signed [67:0]  w_num_n, w_num_f, w_root;
    logic [NUMM_W-1:0]   r_nm_n, r_nm_f;
    logic                r_nm_pos_n, r_nm_pos_f;
    logic [63:0]         r_nm_a;
    logic                r_nm_miss;

    assign w_root  = $signed({2'b00, r_sq_root[SQ_STEPS]});
    assign w_num_n = -68'(r_sq_b[SQ_STEPS]) - w_root;
    assign w_num_f = -68'(r_sq_b[SQ_STEPS]) + w_root;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nm_n     <= w_num_n[NUMM_W-1:0];
            r_nm_f     <= w_num_f[NUMM_W-1:0];
            r_nm_pos_n <= !w_num_n[67] && (w_num_n != '0);
            r_nm_pos_f <= !w_num_f[67] && (w_num_f != '0);
            r_nm_a     <= r_sq_a[SQ_STEPS];
            r_nm_miss  <= r_sq_miss[SQ_STEPS];
        end
    end

    // Restoring division, one quotient bit per stage, both roots side by side.
    logic [DV_W-1:0]   r_dv_rem_n [DIST_W+1];
    logic [DV_W-1:0]   r_dv_rem_f [DIST_W+1];
    logic [DIST_W-1:0] r_dv_q_n   [DIST_W+1];
    logic [DIST_W-1:0] r_dv_q_f   [DIST_W+1];
    logic              r_dv_sat_n [DIST_W+1];
    logic              r_dv_sat_f [DIST_W+1];
    logic              r_dv_pos_n [DIST_W+1];
    logic              r_dv_pos_f [DIST_W+1];
    logic [63:0]       r_dv_a     [DIST_W+1];
    logic              r_dv_miss  [DIST_W+1];

    logic [DV_W-1:0] w_nn, w_nf, w_lim;

    assign w_nn  = DV_W'(r_nm_n) << FRAC_BITS;
    assign w_nf  = DV_W'(r_nm_f) << FRAC_BITS;
    assign w_lim = DV_W'(r_nm_a) << DIST_W;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_rem_n[0] <= w_nn;
            r_dv_rem_f[0] <= w_nf;
            r_dv_q_n[0]   <= '0;
            r_dv_q_f[0]   <= '0;
            r_dv_sat_n[0] <= (w_nn >= w_lim);
            r_dv_sat_f[0] <= (w_nf >= w_lim);
            r_dv_pos_n[0] <= r_nm_pos_n;
            r_dv_pos_f[0] <= r_nm_pos_f;
            r_dv_a[0]     <= r_nm_a;
            r_dv_miss[0]  <= r_nm_miss;
        end
    end

    for (genvar k = 0; k < DIST_W; k++) begin : g_dv
        logic [DV_W-1:0] w_dsh;
        logic            w_take_n, w_take_f;

        assign w_dsh    = DV_W'(r_dv_a[k]) << (DIST_W - 1 - k);
        assign w_take_n = (r_dv_rem_n[k] >= w_dsh);
        assign w_take_f = (r_dv_rem_f[k] >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rem_n[k+1] <= w_take_n ? (r_dv_rem_n[k] - w_dsh) : r_dv_rem_n[k];
                r_dv_rem_f[k+1] <= w_take_f ? (r_dv_rem_f[k] - w_dsh) : r_dv_rem_f[k];
                r_dv_q_n[k+1]   <= {r_dv_q_n[k][DIST_W-2:0], w_take_n};
                r_dv_q_f[k+1]   <= {r_dv_q_f[k][DIST_W-2:0], w_take_f};
                r_dv_sat_n[k+1] <= r_dv_sat_n[k];
                r_dv_sat_f[k+1] <= r_dv_sat_f[k];
                r_dv_pos_n[k+1] <= r_dv_pos_n[k];
                r_dv_pos_f[k+1] <= r_dv_pos_f[k];
                r_dv_a[k+1]     <= r_dv_a[k];
                r_dv_miss[k+1]  <= r_dv_miss[k];
            end
        end
    end

    logic [DIST_W-1:0] w_t_n, w_t_f, w_min;
    rsi_pkg::t_hit     r_out, n_out;

    assign w_min = DIST_W'(r_mind);
    assign w_t_n = !r_dv_pos_n[DIST_W] ? '0 :
                   r_dv_sat_n[DIST_W] ? rsi_pkg::DIST_MAX : r_dv_q_n[DIST_W];
    assign w_t_f = !r_dv_pos_f[DIST_W] ? '0 :
                   r_dv_sat_f[DIST_W] ? rsi_pkg::DIST_MAX : r_dv_q_f[DIST_W];

    always_comb begin
        n_out = '0;
        priority if (r_dv_miss[DIST_W]) begin
            n_out = '0;
        end else if (w_t_n > w_min) begin
            n_out.hit      = 1'b1;
            n_out.distance = w_t_n;
        end else if (w_t_f > w_min) begin
            n_out.hit      = 1'b1;
            n_out.far_root = 1'b1;
            n_out.distance = w_t_f;
        end else begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_hit.data = r_out;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid && !o_hit.data.hit |->
            !o_hit.data.far_root && (o_hit.data.distance == '0))
        else $error("miss beat carries a non-zero payload");

    a_hit_beyond_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid && o_hit.data.hit |-> (o_hit.data.distance > DIST_W'(r_mind)))
        else $error("hit distance does not exceed the minimum");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid && !o_hit.ready |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule
